// ===== hdl/fcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbs_pkg
// Shared types and constants of the frustum culling unit.
// ----------------------------------------------------------------------------
package fcbs_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int NORM_W      = 16;
    localparam int OFFS_W      = 16;
    localparam int NORM_FRAC   = 14;
    localparam int OFFS_LSB    = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    typedef logic [PLANE_COUNT-1:0][CFG_DATA_W-1:0] t_plane_set;

    // load enables of the three stages ahead of the output register
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

endpackage

// ===== hdl/fcbs_if.sv =====
// ----------------------------------------------------------------------------
// fcbs_if
// Valid/ready channels of the frustum culling unit: items, results, config.
// ----------------------------------------------------------------------------
interface fcbs_item_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;
    logic signed [COORD_WIDTH-1:0] sphere_x;
    logic signed [COORD_WIDTH-1:0] sphere_y;
    logic signed [COORD_WIDTH-1:0] sphere_z;
    logic        [COORD_WIDTH-2:0] sphere_radius;

    modport source (
        output valid, func, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z,
               sphere_x, sphere_y, sphere_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, func, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z,
               sphere_x, sphere_y, sphere_z, sphere_radius,
        output ready
    );
endinterface

interface fcbs_result_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

interface fcbs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fcbs_pkg::CFG_IDX_W-1:0]  index;
    logic [fcbs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/fcbs_plane_regs.sv =====
// ----------------------------------------------------------------------------
// fcbs_plane_regs
// The six plane registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module fcbs_plane_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fcbs_cfg_if.sink              i_cfg,
    output fcbs_pkg::t_plane_set  o_planes
);

    fcbs_pkg::t_plane_set r_planes;

    assign i_cfg.ready = 1'b1;
    assign o_planes    = r_planes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (i_cfg.valid) begin
            // out-of-range index is dropped
            for (int k = 0; k < fcbs_pkg::PLANE_COUNT; k++) begin
                if (i_cfg.index == fcbs_pkg::CFG_IDX_W'(k)) begin
                    r_planes[k] <= i_cfg.data;
                end
            end
        end
    end

endmodule

// ===== hdl/fcbs_corner_sel.sv =====
// ----------------------------------------------------------------------------
// fcbs_corner_sel
// Stage 1: per plane, picks the test point (sphere center or positive corner).
// ----------------------------------------------------------------------------
module fcbs_corner_sel #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  fcbs_pkg::t_pipe_ctl           i_ctl,
    input  fcbs_pkg::t_plane_set          i_planes,
    input  logic                          i_func,
    input  logic signed [COORD_WIDTH-1:0] i_mn [3],
    input  logic signed [COORD_WIDTH-1:0] i_mx [3],
    input  logic signed [COORD_WIDTH-1:0] i_ctr [3],
    input  logic        [COORD_WIDTH-2:0] i_radius,
    output logic signed [COORD_WIDTH-1:0] o_pt [fcbs_pkg::PLANE_COUNT][3],
    output logic                          o_func,
    output logic        [COORD_WIDTH-2:0] o_radius
);

    logic signed [COORD_WIDTH-1:0] n_pt [fcbs_pkg::PLANE_COUNT][3];
    logic signed [COORD_WIDTH-1:0] r_pt [fcbs_pkg::PLANE_COUNT][3];
    logic                          r_func;
    logic        [COORD_WIDTH-2:0] r_radius;

    always_comb begin
        for (int k = 0; k < fcbs_pkg::PLANE_COUNT; k++) begin
            for (int a = 0; a < 3; a++) begin
                if (!i_func) begin
                    n_pt[k][a] = i_ctr[a];
                end else if (i_planes[k][fcbs_pkg::NORM_W*a + fcbs_pkg::NORM_W-1]) begin
                    n_pt[k][a] = i_mn[a];
                end else begin
                    // zero component counts as non-negative
                    n_pt[k][a] = i_mx[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_pt     <= n_pt;
            r_func   <= i_func;
            r_radius <= i_radius;
        end
    end

    assign o_pt     = r_pt;
    assign o_func   = r_func;
    assign o_radius = r_radius;

endmodule

// ===== hdl/fcbs_dot.sv =====
// ----------------------------------------------------------------------------
// fcbs_dot
// Stages 2 and 3 for one plane: three products, then their sum and the bias.
// ----------------------------------------------------------------------------
module fcbs_dot #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           i_clk,
    input  fcbs_pkg::t_pipe_ctl            i_ctl,
    input  logic [fcbs_pkg::CFG_DATA_W-1:0] i_plane,
    input  logic signed [COORD_WIDTH-1:0]  i_pt [3],
    input  logic                           i_func,
    input  logic        [COORD_WIDTH-2:0]  i_radius,
    output logic signed [((COORD_WIDTH + fcbs_pkg::NORM_W > 30) ?
                          COORD_WIDTH + fcbs_pkg::NORM_W : 30) + 2:0] o_psum,
    output logic signed [((COORD_WIDTH + fcbs_pkg::NORM_W > 30) ?
                          COORD_WIDTH + fcbs_pkg::NORM_W : 30) + 2:0] o_bias
);

    localparam int PW    = COORD_WIDTH + fcbs_pkg::NORM_W;
    localparam int SUM_W = ((PW > 30) ? PW : 30) + 3;

    logic signed [PW-1:0]               n_prod [3];
    logic signed [PW-1:0]               r_prod [3];
    logic signed [fcbs_pkg::NORM_W-1:0] nrm [3];
    logic signed [fcbs_pkg::OFFS_W-1:0] offs;
    logic signed [SUM_W-1:0]            n_bias;
    logic signed [SUM_W-1:0]            r_bias2;
    logic signed [SUM_W-1:0]            r_bias3;
    logic signed [SUM_W-1:0]            r_psum;

    assign offs = i_plane[fcbs_pkg::OFFS_LSB +: fcbs_pkg::OFFS_W];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            nrm[a]    = i_plane[fcbs_pkg::NORM_W*a +: fcbs_pkg::NORM_W];
            n_prod[a] = PW'(nrm[a]) * PW'(i_pt[a]);
        end
        // offset and (sphere only) radius, both scaled to the Q.14 grid
        n_bias = (SUM_W'(offs) <<< fcbs_pkg::NORM_FRAC)
               + (i_func ? '0
                         : (SUM_W'({1'b0, i_radius}) <<< fcbs_pkg::NORM_FRAC));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_prod  <= n_prod;
            r_bias2 <= n_bias;
        end
        if (i_ctl.ld3) begin
            r_psum  <= SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]);
            r_bias3 <= r_bias2;
        end
    end

    assign o_psum = r_psum;
    assign o_bias = r_bias3;

endmodule

// ===== hdl/frustum_cull_box_sphere_unit.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_box_sphere_unit
// Tests one sphere or box per transaction against six frustum planes.
// ----------------------------------------------------------------------------
// Channels: i_item takes one bounding volume per transaction (func 0 sphere,
// func 1 box), o_result returns one visible bit per item in the same order,
// i_cfg writes plane registers 0..5 (left, right, top, bottom, near, far).
// i_cfg is always ready; write planes only while no item is in flight.
// The four register stages are corner select, plane multiplies, product sum,
// and the bias add with the six-way cull test feeding the output register.
// Throughput: one item per cycle unless the stall below holds the input; the
// 18 multipliers run in parallel, one per plane and axis.
// Reset: all stages go empty and the planes clear to zero, which makes every
// volume visible until the planes are written.
// Stall: when o_result.ready is low the result holds; earlier stages keep
// filling bubbles and i_item.ready drops only once all four stages are full.
// ----------------------------------------------------------------------------
module frustum_cull_box_sphere_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fcbs_item_if.sink    i_item,
    fcbs_cfg_if.sink     i_cfg,
    fcbs_result_if.source o_result
);

    localparam int PW    = COORD_WIDTH + fcbs_pkg::NORM_W;
    localparam int SUM_W = ((PW > 30) ? PW : 30) + 3;

    fcbs_pkg::t_plane_set          planes;
    fcbs_pkg::t_pipe_ctl           ctl;
    logic                          rdy1, rdy2, rdy3, rdy4;
    logic                          r_v1, r_v2, r_v3, r_v4;
    logic                          r_visible;
    logic                          n_visible;
    logic signed [COORD_WIDTH-1:0] mn [3];
    logic signed [COORD_WIDTH-1:0] mx [3];
    logic signed [COORD_WIDTH-1:0] ctr [3];
    logic signed [COORD_WIDTH-1:0] pt [fcbs_pkg::PLANE_COUNT][3];
    logic                          s1_func;
    logic        [COORD_WIDTH-2:0] s1_radius;
    logic signed [SUM_W-1:0]       psum [fcbs_pkg::PLANE_COUNT];
    logic signed [SUM_W-1:0]       bias [fcbs_pkg::PLANE_COUNT];
    logic signed [SUM_W-1:0]       plane_d [fcbs_pkg::PLANE_COUNT];
    logic [fcbs_pkg::PLANE_COUNT-1:0] culled;

    // a stage loads when empty or when the stage after it moves
    assign rdy4 = !r_v4 || o_result.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign ctl.ld1 = rdy1;
    assign ctl.ld2 = rdy2;
    assign ctl.ld3 = rdy3;

    assign i_item.ready    = rdy1;
    assign o_result.valid  = r_v4;
    assign o_result.visible = r_visible;

    assign mn[0]  = i_item.box_min_x;
    assign mn[1]  = i_item.box_min_y;
    assign mn[2]  = i_item.box_min_z;
    assign mx[0]  = i_item.box_max_x;
    assign mx[1]  = i_item.box_max_y;
    assign mx[2]  = i_item.box_max_z;
    assign ctr[0] = i_item.sphere_x;
    assign ctr[1] = i_item.sphere_y;
    assign ctr[2] = i_item.sphere_z;

    fcbs_plane_regs u_planes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_planes (planes)
    );

    fcbs_corner_sel #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sel (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_planes (planes),
        .i_func   (i_item.func),
        .i_mn     (mn),
        .i_mx     (mx),
        .i_ctr    (ctr),
        .i_radius (i_item.sphere_radius),
        .o_pt     (pt),
        .o_func   (s1_func),
        .o_radius (s1_radius)
    );

    for (genvar k = 0; k < fcbs_pkg::PLANE_COUNT; k++) begin : g_plane
        fcbs_dot #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_dot (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_plane  (planes[k]),
            .i_pt     (pt[k]),
            .i_func   (s1_func),
            .i_radius (s1_radius),
            .o_psum   (psum[k]),
            .o_bias   (bias[k])
        );
    end

    always_comb begin
        for (int k = 0; k < fcbs_pkg::PLANE_COUNT; k++) begin
            plane_d[k] = psum[k] + bias[k];
            culled[k]  = plane_d[k][SUM_W-1];
        end
        n_visible = ~|culled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_item.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_visible <= n_visible;
        end
    end

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v4 && !r_v1)
        else $error("pipeline not empty after reset");

    a_out_from_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v4) |-> $past(r_v3))
        else $error("result appeared without an item in stage 3");

    a_s2_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v2) |-> $past(r_v1))
        else $error("stage 2 filled without an item in stage 1");

    a_stall_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !o_result.ready) |-> !i_item.ready)
        else $error("item taken while all stages are held");
`endif

endmodule
